// ----- src/ate_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_pkg: shared types and constants of the animation timeline engine
// Payload structs, state codes, register map and datapath widths.
// ----------------------------------------------------------------------------
package ate_pkg;

    localparam int STAMP_BITS = 32;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DUR_BITS   = 20;
    localparam int LOOP_BITS  = 16;
    localparam int FRAME_BITS = 32;
    localparam int ELAP_BITS  = 40;
    localparam int TOTAL_BITS = DUR_BITS + LOOP_BITS;
    localparam int OP_BITS    = 3;
    localparam int CODE_BITS  = 3;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;
    localparam int IDX_BITS   = 3;

    localparam int DIV_CNT_BITS = $clog2(ELAP_BITS);
    localparam int F_BITS       = FRAC_BITS + 1;
    localparam int DIFF_BITS    = VALUE_BITS + 1;
    localparam int PROD_BITS    = DIFF_BITS + F_BITS + 1;
    localparam int SUM_BITS     = PROD_BITS + 1;

    localparam logic [ELAP_BITS-1:0] ELAP_MAX =
        ELAP_BITS'((64'd1 << (ELAP_BITS - 1)) - 64'd1);

    localparam logic [DUR_BITS-1:0]   DUR_RESET   = DUR_BITS'(1000);
    localparam logic [LOOP_BITS-1:0]  LOOP_RESET  = LOOP_BITS'(1);
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = TOTAL_BITS'(1000);

    typedef enum logic [CODE_BITS-1:0] {
        RS_STOPPED = 3'd0,
        RS_READY   = 3'd1,
        RS_RUNNING = 3'd2,
        RS_PAUSED  = 3'd3,
        RS_REMOVED = 3'd4
    } t_run_state;

    typedef enum logic [OP_BITS-1:0] {
        OP_ARM    = 3'd0,
        OP_LAUNCH = 3'd1,
        OP_TICK   = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_RESUME = 3'd4,
        OP_STOP   = 3'd5
    } t_op;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DURATION = 3'd0,
        REG_LOOPS    = 3'd1,
        REG_FOREVER  = 3'd2,
        REG_BACKWARD = 3'd3,
        REG_KEEP     = 3'd4,
        REG_START    = 3'd5,
        REG_END      = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_DIVQ,
        SQ_DIVF,
        SQ_MUL,
        SQ_SUM,
        SQ_PUSH
    } t_seq_state;

    typedef struct packed {
        logic [OP_BITS-1:0]    op;
        logic [STAMP_BITS-1:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [CODE_BITS-1:0]         state_code;
        logic                         still_running;
        logic [DUR_BITS-1:0]          local_time;
        logic [LOOP_BITS-1:0]         loop_index;
        logic [FRAME_BITS-1:0]        frame_count;
        logic signed [VALUE_BITS-1:0] current_value;
        logic                         loop_changed;
        logic                         finished;
    } t_out_item;

    typedef struct packed {
        logic [DUR_BITS-1:0]          dur_eff;
        logic [LOOP_BITS-1:0]         loop_total;
        logic                         loop_forever;
        logic                         run_backward;
        logic                         keep_alive;
        logic signed [VALUE_BITS-1:0] start_value;
        logic signed [VALUE_BITS-1:0] end_value;
        logic [TOTAL_BITS-1:0]        total;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [ELAP_BITS-1:0] dividend;
        logic [DUR_BITS-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [ELAP_BITS-1:0] quotient;
        logic [DUR_BITS-1:0]  remainder;
    } t_div_rsp;

endpackage

// ----- src/ate_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_div: shared restoring divider
// One quotient bit per cycle; serves the loop split and the tween factor.
// ----------------------------------------------------------------------------
module ate_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ate_pkg::t_div_req i_req,
    output ate_pkg::t_div_rsp o_rsp
);

    localparam logic [ate_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
        ate_pkg::DIV_CNT_BITS'(ate_pkg::ELAP_BITS - 1);

    logic                                r_busy;
    logic                                r_done;
    logic [ate_pkg::DIV_CNT_BITS-1:0]    r_cnt;
    logic [ate_pkg::ELAP_BITS-1:0]       r_quo;
    logic [ate_pkg::DUR_BITS-1:0]        r_rem;
    logic [ate_pkg::DUR_BITS-1:0]        r_dvs;
    logic [ate_pkg::DUR_BITS:0]          w_shift;
    logic [ate_pkg::DUR_BITS:0]          w_trial;
    logic                                w_ge;

    // shift in the next dividend bit and trial-subtract
    assign w_shift = {r_rem, r_quo[ate_pkg::ELAP_BITS-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ate_pkg::ELAP_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_trial[ate_pkg::DUR_BITS-1:0] : w_shift[ate_pkg::DUR_BITS-1:0];
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

endmodule

// ----- src/ate_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_cfg_regs: configuration register bank
// APB-style write/read access; precomputes effective duration and run length.
// ----------------------------------------------------------------------------
module ate_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ate_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [ate_pkg::DATA_BITS-1:0]   pwdata,
    output logic [ate_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    output ate_pkg::t_cfg                   o_cfg
);

    logic [ate_pkg::DUR_BITS-1:0]          r_duration;
    logic [ate_pkg::LOOP_BITS-1:0]         r_loops;
    logic                                  r_forever;
    logic                                  r_backward;
    logic                                  r_keep;
    logic [ate_pkg::VALUE_BITS-1:0]        r_start;
    logic [ate_pkg::VALUE_BITS-1:0]        r_end;
    logic [ate_pkg::TOTAL_BITS-1:0]        r_total;
    logic [ate_pkg::DUR_BITS-1:0]          w_dur_eff;
    logic                                  w_wr;
    ate_pkg::t_reg_idx                     w_idx;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_idx     = ate_pkg::t_reg_idx'(paddr[ate_pkg::ADDR_BITS-1:2]);
    // zero duration behaves as one
    assign w_dur_eff = (r_duration == '0) ? ate_pkg::DUR_BITS'(1) : r_duration;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= ate_pkg::DUR_RESET;
            r_loops    <= ate_pkg::LOOP_RESET;
            r_forever  <= 1'b0;
            r_backward <= 1'b0;
            r_keep     <= 1'b1;
            r_start    <= '0;
            r_end      <= '0;
            r_total    <= ate_pkg::TOTAL_RESET;
        end else begin
            r_total <= w_dur_eff * r_loops;
            if (w_wr) begin
                case (w_idx)
                    ate_pkg::REG_DURATION: r_duration <= pwdata[ate_pkg::DUR_BITS-1:0];
                    ate_pkg::REG_LOOPS:    r_loops    <= pwdata[ate_pkg::LOOP_BITS-1:0];
                    ate_pkg::REG_FOREVER:  r_forever  <= pwdata[0];
                    ate_pkg::REG_BACKWARD: r_backward <= pwdata[0];
                    ate_pkg::REG_KEEP:     r_keep     <= pwdata[0];
                    ate_pkg::REG_START:    r_start    <= pwdata[ate_pkg::VALUE_BITS-1:0];
                    ate_pkg::REG_END:      r_end      <= pwdata[ate_pkg::VALUE_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (w_idx)
            ate_pkg::REG_DURATION: prdata = ate_pkg::DATA_BITS'(r_duration);
            ate_pkg::REG_LOOPS:    prdata = ate_pkg::DATA_BITS'(r_loops);
            ate_pkg::REG_FOREVER:  prdata = ate_pkg::DATA_BITS'(r_forever);
            ate_pkg::REG_BACKWARD: prdata = ate_pkg::DATA_BITS'(r_backward);
            ate_pkg::REG_KEEP:     prdata = ate_pkg::DATA_BITS'(r_keep);
            ate_pkg::REG_START:    prdata = ate_pkg::DATA_BITS'(r_start);
            ate_pkg::REG_END:      prdata = ate_pkg::DATA_BITS'(r_end);
            default:               prdata = '0;
        endcase
    end

    assign o_cfg.dur_eff      = w_dur_eff;
    assign o_cfg.loop_total   = r_loops;
    assign o_cfg.loop_forever = r_forever;
    assign o_cfg.run_backward = r_backward;
    assign o_cfg.keep_alive   = r_keep;
    assign o_cfg.start_value  = r_start;
    assign o_cfg.end_value    = r_end;
    assign o_cfg.total        = r_total;

endmodule

// ----- src/animation_timeline_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_timeline_engine: one animation timeline with a linear tween
// Control events and timestamp ticks in, one status/value beat out per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_data) takes one beat per item:
//   an op code (arm, launch, tick, pause, resume, stop) and a timestamp.
//   Output channel (o_out_valid/i_out_ready/o_out_data) gives exactly one
//   beat per item: state, loop index, frame count and, for a running tick,
//   the local time, tweened value and loop/finish flags.
//   Control items and ticks while not running go from acceptance through
//   the push state into the output register. A running tick takes two
//   passes through the shared restoring divider (loop split, then tween
//   factor), then a multiply step, a sum step and the output load. The
//   divider passes set the tick rate.
//   One item is in work at a time; o_in_ready is high only when the
//   sequencer is idle. A finished result waits in the output register, and
//   the next item is taken meanwhile; its result is held back until the
//   receiver takes the earlier beat, so a stalled receiver stalls at most
//   one item.
//   Reset (i_rst_n low, synchronous) brings the timeline to stopped with
//   zero elapsed time, loop and frame counts, and the registers to their
//   defaults. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module animation_timeline_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ate_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ate_pkg::t_out_item            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ate_pkg::ADDR_BITS-1:0] paddr,
    input  logic [ate_pkg::DATA_BITS-1:0] pwdata,
    output logic [ate_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);

    ate_pkg::t_cfg       w_cfg;
    ate_pkg::t_div_req   w_div_req;
    ate_pkg::t_div_rsp   w_div_rsp;

    // sequencer and architectural state
    ate_pkg::t_seq_state r_seq,  n_seq;
    ate_pkg::t_run_state r_run,  n_run;
    logic [ate_pkg::STAMP_BITS-1:0] r_last,    n_last;
    logic [ate_pkg::ELAP_BITS-1:0]  r_elapsed, n_elapsed;
    logic [ate_pkg::LOOP_BITS-1:0]  r_loop,    n_loop;
    logic [ate_pkg::FRAME_BITS-1:0] r_frames,  n_frames;
    logic                           r_fin,     n_fin;
    logic                           r_div_start, n_div_start;
    logic                           r_out_valid, n_out_valid;
    ate_pkg::t_out_item             r_out, n_out;
    ate_pkg::t_out_item             r_res, n_res;

    // datapath holding registers
    logic [ate_pkg::DUR_BITS-1:0]          r_local, n_local;
    logic [ate_pkg::F_BITS-1:0]            r_f,     n_f;
    logic signed [ate_pkg::PROD_BITS-1:0]  r_prod,  n_prod;

    // tick arithmetic
    logic [ate_pkg::STAMP_BITS-1:0]        w_step_u;
    logic signed [ate_pkg::STAMP_BITS:0]   w_step;
    logic signed [ate_pkg::STAMP_BITS:0]   w_delta;
    logic signed [ate_pkg::ELAP_BITS+1:0]  w_e_raw;
    logic [ate_pkg::ELAP_BITS-1:0]         w_hi;
    logic [ate_pkg::ELAP_BITS-1:0]         w_e;
    logic                                  w_done_run;
    logic [ate_pkg::LOOP_BITS-1:0]         w_q_sat;
    logic [ate_pkg::DUR_BITS-1:0]          w_local;
    logic signed [ate_pkg::DIFF_BITS-1:0]  w_diff;
    logic signed [ate_pkg::SUM_BITS-1:0]   w_sum;
    logic signed [ate_pkg::SUM_BITS-1:0]   w_biased;
    logic                                  w_accept;
    ate_pkg::t_run_state                   w_fin_state;

    ate_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ate_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_ready = (r_seq == ate_pkg::SQ_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fin_state = w_cfg.keep_alive ? ate_pkg::RS_STOPPED : ate_pkg::RS_REMOVED;

    // First pass splits elapsed time into loop and remainder; second pass
    // turns local time into the fixed-point tween factor.
    assign w_div_req.start    = r_div_start;
    assign w_div_req.divisor  = w_cfg.dur_eff;
    assign w_div_req.dividend = (r_seq == ate_pkg::SQ_DIVF)
        ? ate_pkg::ELAP_BITS'({r_local, ate_pkg::FRAC_BITS'(0)})
        : r_elapsed;

    // Signed stamp difference, flipped for a backward run, then clamp the
    // new elapsed time to zero and the upper bound.
    assign w_step_u = i_in_data.time_ms - r_last;
    assign w_step   = $signed({w_step_u[ate_pkg::STAMP_BITS-1], w_step_u});
    assign w_delta  = w_cfg.run_backward ? -w_step : w_step;
    assign w_e_raw  = $signed({2'b00, r_elapsed}) + (ate_pkg::ELAP_BITS + 2)'(w_delta);
    assign w_hi     = w_cfg.loop_forever ? ate_pkg::ELAP_MAX
                                         : ate_pkg::ELAP_BITS'(w_cfg.total);

    always_comb begin
        if (w_e_raw[ate_pkg::ELAP_BITS+1]) begin
            w_e = '0;
        end else if (w_e_raw[ate_pkg::ELAP_BITS:0] > {1'b0, w_hi}) begin
            w_e = w_hi;
        end else begin
            w_e = w_e_raw[ate_pkg::ELAP_BITS-1:0];
        end
    end

    // Forward finite run ends at the full length, backward run at zero.
    assign w_done_run =
        (!w_cfg.run_backward && !w_cfg.loop_forever &&
         (w_e == ate_pkg::ELAP_BITS'(w_cfg.total))) ||
        (w_cfg.run_backward && (w_e == '0));

    // Saturate loop index; an exact nonzero multiple shows the full duration.
    assign w_q_sat = (|w_div_rsp.quotient[ate_pkg::ELAP_BITS-1:ate_pkg::LOOP_BITS])
        ? '1 : w_div_rsp.quotient[ate_pkg::LOOP_BITS-1:0];
    assign w_local = ((r_elapsed != '0) && (w_div_rsp.remainder == '0))
        ? w_cfg.dur_eff : w_div_rsp.remainder;

    assign w_diff = $signed({w_cfg.end_value[ate_pkg::VALUE_BITS-1], w_cfg.end_value})
                  - $signed({w_cfg.start_value[ate_pkg::VALUE_BITS-1], w_cfg.start_value});

    // start * 2^FRAC + diff * f, then truncate toward zero.
    assign w_sum    = ate_pkg::SUM_BITS'(r_prod)
                    + (ate_pkg::SUM_BITS'(w_cfg.start_value) <<< ate_pkg::FRAC_BITS);
    assign w_biased = w_sum + (w_sum[ate_pkg::SUM_BITS-1]
                    ? ate_pkg::SUM_BITS'((1 << ate_pkg::FRAC_BITS) - 1)
                    : ate_pkg::SUM_BITS'(0));

    always_comb begin
        n_seq       = r_seq;
        n_run       = r_run;
        n_last      = r_last;
        n_elapsed   = r_elapsed;
        n_loop      = r_loop;
        n_frames    = r_frames;
        n_fin       = r_fin;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_res       = r_res;
        n_local     = r_local;
        n_f         = r_f;
        n_prod      = r_prod;

        // drop the beat once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            ate_pkg::SQ_IDLE: begin
                if (w_accept) begin
                    n_res = '0;
                    n_seq = ate_pkg::SQ_PUSH;
                    case (ate_pkg::t_op'(i_in_data.op))
                        ate_pkg::OP_ARM: begin
                            if (r_run != ate_pkg::RS_READY) begin
                                if (r_run == ate_pkg::RS_STOPPED ||
                                    r_run == ate_pkg::RS_REMOVED) begin
                                    n_frames  = '0;
                                    n_elapsed = w_cfg.run_backward
                                        ? ate_pkg::ELAP_BITS'(w_cfg.total) : '0;
                                end
                                n_run = ate_pkg::RS_READY;
                            end
                        end
                        ate_pkg::OP_LAUNCH: begin
                            if (r_run == ate_pkg::RS_READY) begin
                                n_last = i_in_data.time_ms;
                                n_run  = ate_pkg::RS_RUNNING;
                            end
                        end
                        ate_pkg::OP_TICK: begin
                            n_last = i_in_data.time_ms;
                            if (r_run == ate_pkg::RS_RUNNING) begin
                                n_elapsed   = w_e;
                                n_fin       = w_done_run;
                                n_frames    = r_frames + 1'b1;
                                n_div_start = 1'b1;
                                n_seq       = ate_pkg::SQ_DIVQ;
                            end
                        end
                        ate_pkg::OP_PAUSE: begin
                            if (r_run == ate_pkg::RS_RUNNING) begin
                                n_run = ate_pkg::RS_PAUSED;
                            end
                        end
                        ate_pkg::OP_RESUME: begin
                            if (r_run == ate_pkg::RS_PAUSED) begin
                                n_run = ate_pkg::RS_READY;
                            end
                        end
                        ate_pkg::OP_STOP: begin
                            if (r_run != ate_pkg::RS_STOPPED) begin
                                n_run          = w_fin_state;
                                n_res.finished = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ate_pkg::SQ_DIVQ: begin
                if (w_div_rsp.done) begin
                    n_local            = w_local;
                    n_res.local_time   = w_local;
                    n_res.loop_changed = (w_q_sat != r_loop);
                    n_loop             = w_q_sat;
                    if (r_fin) begin
                        n_run          = w_fin_state;
                        n_res.finished = 1'b1;
                    end else begin
                        n_res.still_running = 1'b1;
                    end
                    n_div_start = 1'b1;
                    n_seq       = ate_pkg::SQ_DIVF;
                end
            end
            ate_pkg::SQ_DIVF: begin
                if (w_div_rsp.done) begin
                    n_f   = w_div_rsp.quotient[ate_pkg::F_BITS-1:0];
                    n_seq = ate_pkg::SQ_MUL;
                end
            end
            ate_pkg::SQ_MUL: begin
                n_prod = w_diff * $signed({1'b0, r_f});
                n_seq  = ate_pkg::SQ_SUM;
            end
            ate_pkg::SQ_SUM: begin
                n_res.current_value =
                    w_biased[ate_pkg::FRAC_BITS +: ate_pkg::VALUE_BITS];
                n_seq = ate_pkg::SQ_PUSH;
            end
            ate_pkg::SQ_PUSH: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res;
                    n_out.state_code  = r_run;
                    n_out.loop_index  = r_loop;
                    n_out.frame_count = r_frames;
                    n_out_valid       = 1'b1;
                    n_seq             = ate_pkg::SQ_IDLE;
                end
            end
            default: begin
                n_seq = ate_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= ate_pkg::SQ_IDLE;
            r_run       <= ate_pkg::RS_STOPPED;
            r_last      <= '0;
            r_elapsed   <= '0;
            r_loop      <= '0;
            r_frames    <= '0;
            r_fin       <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_run       <= n_run;
            r_last      <= n_last;
            r_elapsed   <= n_elapsed;
            r_loop      <= n_loop;
            r_frames    <= n_frames;
            r_fin       <= n_fin;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_res   <= n_res;
        r_local <= n_local;
        r_f     <= n_f;
        r_prod  <= n_prod;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fin_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.finished) |->
        (o_out_data.state_code == ate_pkg::RS_STOPPED ||
         o_out_data.state_code == ate_pkg::RS_REMOVED))
        else $error("finished beat without a stopped or removed state");

    a_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.finished && o_out_data.still_running))
        else $error("beat both finished and still running");

    a_div_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_seq == ate_pkg::SQ_DIVQ || r_seq == ate_pkg::SQ_DIVF))
        else $error("divider started outside a divide step");

    a_loop_only_divq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loop != $past(r_loop) && $past(i_rst_n)) |->
        ($past(r_seq) == ate_pkg::SQ_DIVQ))
        else $error("loop index changed outside the loop split");

endmodule

// ----- tb/animation_timeline_engine_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animation_timeline_engine_tb: self-checking bench for the timeline engine
// Drives control and tick beats through the input channel and writes the
// registers over APB. Every accepted beat is run through a local timeline
// predictor, and each status beat that comes out is compared against it.
// Directed runs cover the control paths, the clamps and the saturation
// limits. Random sessions then run under three idle/stall mixes, plus one
// long output hold-off.
// ----------------------------------------------------------------------------
module animation_timeline_engine_tb;
    import ate_pkg::*;

    // Op codes that the block does not decode; they must report state only.
    localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;

    localparam int          HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int          RANDOM_ITEMS  = 240;  // per idle/stall mix
    localparam int          CEILING_TICKS = 260;  // enough to pin elapsed at its max
    localparam int          SETTLE_CYCLES = 100;  // beyond a running tick's latency
    localparam logic [31:0] MAX_STEP      = 32'h7FFF_FFFF;

    // ------------------------------------------------------------------------
    // Block inputs: all start at known values, reset held low from time zero.
    // ------------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_BITS-1:0]  paddr     = '0;
    logic [DATA_BITS-1:0]  pwdata    = '0;

    logic                  in_ready;
    logic                  out_valid;
    t_out_item             out_data;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    // ------------------------------------------------------------------------
    // Local copy of the timeline: registers and state, at their reset values.
    // ------------------------------------------------------------------------
    logic [DUR_BITS-1:0]          cfg_duration = DUR_RESET;
    logic [LOOP_BITS-1:0]         cfg_loops    = LOOP_RESET;
    logic                         cfg_forever  = 1'b0;
    logic                         cfg_backward = 1'b0;
    logic                         cfg_keep     = 1'b1;
    logic signed [VALUE_BITS-1:0] cfg_start    = '0;
    logic signed [VALUE_BITS-1:0] cfg_end      = '0;

    t_run_state                   tl_state   = RS_STOPPED;
    logic [STAMP_BITS-1:0]        tl_stamp   = '0;
    longint                       tl_elapsed = 0;
    logic [LOOP_BITS-1:0]         tl_loop    = '0;
    logic [FRAME_BITS-1:0]        tl_frames  = '0;

    // Status beats predicted but not yet seen, oldest first.
    t_out_item status_due[$];

    // Idle mix, in percent per cycle; the receiver hold-off is requested by
    // bumping rx_hold_reqs and is counted down inside the receiver process.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          rx_hold_reqs   = 0;
    int          rx_hold_seen   = 0;
    int          rx_hold_left   = 0;

    logic [STAMP_BITS-1:0] wall_ms = '0;

    int mismatches    = 0;
    int items_sent    = 0;
    int beats_checked = 0;
    int runs_finished = 0;
    int reg_writes    = 0;

    animation_timeline_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Timeline predictor: apply one event beat to the local copy and return
    // the status beat it should produce.
    // ------------------------------------------------------------------------
    function automatic t_out_item advance_timeline(input t_in_item beat);
        t_out_item             res;
        longint                span_d, total, e, ceiling, delta;
        longint                rem, loop_q, local_t, frac, s, diff, sum, val;
        logic [STAMP_BITS-1:0] gap, mag;
        res = '0;
        // A zero duration counts as one unit.
        span_d = (cfg_duration == '0) ? 64'sd1 : longint'({44'd0, cfg_duration});
        total  = span_d * longint'({48'd0, cfg_loops});
        case (beat.op)
            OP_ARM: begin
                if (tl_state != RS_READY) begin
                    // Re-arming a finished run restarts it from its start point.
                    if (tl_state == RS_STOPPED || tl_state == RS_REMOVED) begin
                        tl_frames  = '0;
                        tl_elapsed = cfg_backward ? total : 0;
                    end
                    tl_state = RS_READY;
                end
            end
            OP_LAUNCH: begin
                if (tl_state == RS_READY) begin
                    tl_stamp = beat.time_ms;
                    tl_state = RS_RUNNING;
                end
            end
            OP_TICK: begin
                // Signed stamp difference; the sign flips when running backward.
                gap   = beat.time_ms - tl_stamp;
                mag   = gap[STAMP_BITS-1] ? -gap : gap;
                delta = longint'({32'd0, mag});
                if (gap[STAMP_BITS-1] != cfg_backward)
                    delta = -delta;
                tl_stamp = beat.time_ms;
                if (tl_state == RS_RUNNING) begin
                    e       = tl_elapsed + delta;
                    ceiling = cfg_forever ? longint'({24'd0, ELAP_MAX}) : total;
                    if (e < 0)
                        e = 0;
                    if (e > ceiling)
                        e = ceiling;
                    tl_elapsed = e;
                    loop_q = e / span_d;
                    rem    = e % span_d;
                    if (loop_q > 65535)
                        loop_q = 65535;
                    // An exact nonzero multiple shows as the full loop length.
                    local_t = (e != 0 && rem == 0) ? span_d : rem;
                    frac    = (local_t << FRAC_BITS) / span_d;
                    s       = longint'(cfg_start);
                    diff    = longint'(cfg_end) - s;
                    sum     = s * (longint'(1) << FRAC_BITS) + diff * frac;
                    val     = (sum < 0) ? -((-sum) >>> FRAC_BITS) : (sum >>> FRAC_BITS);
                    tl_frames = tl_frames + 1'b1;
                    res.loop_changed  = (loop_q[LOOP_BITS-1:0] != tl_loop);
                    tl_loop           = loop_q[LOOP_BITS-1:0];
                    res.local_time    = local_t[DUR_BITS-1:0];
                    res.current_value = val[VALUE_BITS-1:0];
                    if ((!cfg_backward && !cfg_forever && e == total) ||
                        (cfg_backward && e == 0)) begin
                        tl_state     = cfg_keep ? RS_STOPPED : RS_REMOVED;
                        res.finished = 1'b1;
                    end else begin
                        res.still_running = 1'b1;
                    end
                end
            end
            OP_PAUSE: begin
                if (tl_state == RS_RUNNING)
                    tl_state = RS_PAUSED;
            end
            OP_RESUME: begin
                if (tl_state == RS_PAUSED)
                    tl_state = RS_READY;
            end
            OP_STOP: begin
                if (tl_state != RS_STOPPED) begin
                    tl_state     = cfg_keep ? RS_STOPPED : RS_REMOVED;
                    res.finished = 1'b1;
                end
            end
            default: ;
        endcase
        res.state_code  = tl_state;
        res.loop_index  = tl_loop;
        res.frame_count = tl_frames;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Status checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_status(input t_out_item got);
        t_out_item want;
        if (status_due.size() == 0) begin
            $error("status beat 0x%0h arrived with nothing outstanding", got);
            mismatches++;
        end else begin
            want = status_due.pop_front();
            beats_checked++;
            check_field("state_code",    want.state_code,    got.state_code);
            check_field("still_running", want.still_running, got.still_running);
            check_field("local_time",    want.local_time,    got.local_time);
            check_field("loop_index",    want.loop_index,    got.loop_index);
            check_field("frame_count",   want.frame_count,   got.frame_count);
            check_field("current_value", want.current_value, got.current_value);
            check_field("loop_changed",  want.loop_changed,  got.loop_changed);
            check_field("finished",      want.finished,      got.finished);
        end
    endtask

    // Receiver: check the beat taken at this edge, then choose ready for the
    // next cycle. A pending hold-off request overrides the random stalls.
    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = HOLD_CYCLES;
        end
        if (i_rst_n && out_valid && out_ready)
            check_status(out_data);
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender and register access
    // ------------------------------------------------------------------------

    // Offer one event beat, with an optional idle gap in front; predict its
    // status at the edge where it is taken. Valid is left high on return so
    // that back-to-back beats need no drop in between.
    task automatic send_event(input logic [OP_BITS-1:0] op,
                              input logic [STAMP_BITS-1:0] stamp);
        t_in_item  beat;
        t_out_item want;
        beat.op      = op;
        beat.time_ms = stamp;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge i_clk); while (!in_ready);
        want = advance_timeline(beat);
        status_due.push_back(want);
        runs_finished += want.finished;
        items_sent++;
    endtask

    // Drop valid and hold until every predicted status beat has been taken.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (status_due.size() != 0)
            @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then a quiet cycle so that a
    // following write never reassigns psel in the same step.
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DURATION: cfg_duration = value[DUR_BITS-1:0];
            REG_LOOPS:    cfg_loops    = value[LOOP_BITS-1:0];
            REG_FOREVER:  cfg_forever  = value[0];
            REG_BACKWARD: cfg_backward = value[0];
            REG_KEEP:     cfg_keep     = value[0];
            REG_START:    cfg_start    = value;
            REG_END:      cfg_end      = value;
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Tween end point, biased towards the signed extremes.
    function automatic logic [31:0] pick_value();
        int unsigned p;
        p = $urandom_range(9);
        if (p == 0)
            return 32'h8000_0000;
        else if (p == 1)
            return 32'h7FFF_FFFF;
        else if (p == 2)
            return '0;
        return $urandom;
    endfunction

    task automatic pick_settings();
        int unsigned         p;
        logic [DUR_BITS-1:0]  dur;
        logic [LOOP_BITS-1:0] loops;
        p = $urandom_range(99);
        if (p < 70)
            dur = $urandom_range(1, 3000);
        else if (p < 80)
            dur = $urandom_range(0, 1);
        else if (p < 88)
            dur = '1;
        else
            dur = $urandom;
        p = $urandom_range(99);
        if (p < 75)
            loops = $urandom_range(1, 4);
        else if (p < 80)
            loops = '0;
        else if (p < 88)
            loops = '1;
        else
            loops = $urandom;
        write_reg(REG_DURATION, dur);
        write_reg(REG_LOOPS, loops);
        write_reg(REG_FOREVER, $urandom_range(99) < 20);
        write_reg(REG_BACKWARD, $urandom_range(1));
        write_reg(REG_KEEP, $urandom_range(1));
        write_reg(REG_START, pick_value());
        write_reg(REG_END, pick_value());
    endtask

    // One animation session: arm, launch, then mostly ticks with forward
    // steps sized to the configured run, mixed with pauses, re-launches,
    // stops, stamp jumps and stray op codes. Leave once the run has ended.
    task automatic play_session(input int n);
        int          k;
        int unsigned pick;
        longint      span;
        span = (cfg_duration == '0) ? 1 : longint'({44'd0, cfg_duration});
        span = span * ((cfg_forever || cfg_loops == '0) ? 4 : longint'({48'd0, cfg_loops}));
        span = span / 5 + 1;
        if (span > longint'({32'd0, MAX_STEP}))
            span = longint'({32'd0, MAX_STEP});
        send_event(OP_ARM, $urandom);
        send_event(OP_LAUNCH, wall_ms);
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if (pick < 3)
                    wall_ms = $urandom;
                else if (pick < 8)
                    wall_ms = wall_ms - $urandom_range(0, 200);
                else
                    wall_ms = wall_ms + $urandom_range(0, 32'(span));
                send_event(OP_TICK, wall_ms);
            end else if (pick < 76) begin
                send_event(OP_PAUSE, $urandom);
            end else if (pick < 82) begin
                send_event(OP_RESUME, $urandom);
                wall_ms = wall_ms + $urandom_range(0, 50);
                send_event(OP_LAUNCH, wall_ms);
            end else if (pick < 86) begin
                send_event(OP_ARM, $urandom);
                send_event(OP_LAUNCH, wall_ms);
            end else if (pick < 89) begin
                send_event(OP_STOP, $urandom);
            end else begin
                send_event($urandom_range(7), $urandom);
            end
            if (tl_state == RS_STOPPED || tl_state == RS_REMOVED)
                break;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Controls and ticks on a stopped timeline, plus the undecoded op codes.
    task automatic test_idle_controls();
        send_event(OP_TICK, 32'hFFFF_FFFF);
        send_event(OP_PAUSE, '0);
        send_event(OP_RESUME, '0);
        send_event(OP_STOP, '0);
        send_event(OP_LAUNCH, 32'h0000_1234);
        send_event(OP_SPARE_6, $urandom);
        send_event(OP_SPARE_7, $urandom);
    endtask

    // Forward two-loop run across the stamp wrap: exact loop boundary,
    // pause with a lost tick, resume and relaunch, a backward stamp step and
    // an overshoot that clamps and finishes.
    task automatic test_forward_run();
        logic [STAMP_BITS-1:0] t0;
        t0 = 32'hFFFF_FF00;
        wait_drain();
        write_reg(REG_DURATION, 1000);
        write_reg(REG_LOOPS, 2);
        write_reg(REG_FOREVER, 0);
        write_reg(REG_BACKWARD, 0);
        write_reg(REG_KEEP, 1);
        write_reg(REG_START, 32'h8000_0000);
        write_reg(REG_END, 32'h7FFF_FFFF);
        send_event(OP_ARM, '0);
        send_event(OP_ARM, '0);
        send_event(OP_LAUNCH, t0);
        send_event(OP_TICK, t0 + 250);
        send_event(OP_TICK, t0 + 1000);
        send_event(OP_PAUSE, '0);
        send_event(OP_TICK, t0 + 1500);
        send_event(OP_RESUME, '0);
        send_event(OP_LAUNCH, t0 + 1600);
        send_event(OP_TICK, t0 + 1500);
        send_event(OP_TICK, t0 + 9000);
    endtask

    // Backward run without keep-alive: clamp at the top, step back into the
    // middle loop, reach zero and get removed; stop and re-arm from removed.
    task automatic test_backward_run();
        wait_drain();
        write_reg(REG_KEEP, 0);
        write_reg(REG_BACKWARD, 1);
        write_reg(REG_DURATION, 300);
        write_reg(REG_LOOPS, 3);
        write_reg(REG_START, 5);
        write_reg(REG_END, 32'hFFFF_FFF9);
        send_event(OP_ARM, '0);
        send_event(OP_LAUNCH, 10);
        send_event(OP_TICK, 5);
        send_event(OP_TICK, 310);
        send_event(OP_TICK, 2000);
        send_event(OP_STOP, '0);
        send_event(OP_ARM, '0);
        send_event(OP_STOP, '0);
    endtask

    // Looping forever with a zero duration: loop index saturates, the most
    // negative stamp step pins elapsed at zero. Then a short backward
    // forever run that still finishes on reaching zero.
    task automatic test_forever_run();
        wait_drain();
        write_reg(REG_DURATION, 0);
        write_reg(REG_LOOPS, 0);
        write_reg(REG_FOREVER, 1);
        write_reg(REG_BACKWARD, 0);
        write_reg(REG_KEEP, 1);
        send_event(OP_ARM, '0);
        send_event(OP_LAUNCH, '0);
        send_event(OP_TICK, MAX_STEP);
        send_event(OP_TICK, 32'hFFFF_FFFF);
        send_event(OP_STOP, '0);
        wait_drain();
        write_reg(REG_DURATION, 7);
        write_reg(REG_LOOPS, 2);
        write_reg(REG_BACKWARD, 1);
        send_event(OP_ARM, '0);
        send_event(OP_LAUNCH, 100);
        send_event(OP_TICK, 105);
        send_event(OP_TICK, 200);
    endtask

    // Drive elapsed up to its ceiling with the largest forward steps.
    task automatic test_elapsed_ceiling();
        int                    k;
        logic [STAMP_BITS-1:0] stamp;
        stamp = '0;
        wait_drain();
        write_reg(REG_DURATION, 32'h000F_FFFF);
        write_reg(REG_LOOPS, 32'h0000_FFFF);
        write_reg(REG_FOREVER, 1);
        write_reg(REG_BACKWARD, 0);
        send_event(OP_ARM, '0);
        send_event(OP_LAUNCH, stamp);
        for (k = 0; k < CEILING_TICKS; k++) begin
            stamp = stamp + MAX_STEP;
            send_event(OP_TICK, stamp);
        end
        send_event(OP_STOP, '0);
    endtask

    // Hold the receiver off for a long stretch while beats keep coming, so
    // the output register fills and the input stalls; then drain fully.
    task automatic test_output_backpressure();
        int          k;
        int unsigned tx_keep, rx_keep;
        tx_keep = send_idle_pct;
        rx_keep = recv_stall_pct;
        wait_drain();
        write_reg(REG_DURATION, 50);
        write_reg(REG_LOOPS, 3);
        write_reg(REG_FOREVER, 0);
        write_reg(REG_BACKWARD, 0);
        write_reg(REG_KEEP, 1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_reqs++;
        send_event(OP_ARM, '0);
        send_event(OP_LAUNCH, '0);
        for (k = 1; k <= 10; k++)
            send_event(OP_TICK, 7 * k);
        send_event(OP_STOP, '0);
        wait_drain();
        send_idle_pct  = tx_keep;
        recv_stall_pct = rx_keep;
    endtask

    // Random sessions under one idle/stall mix, reconfiguring between them.
    task automatic test_random_sessions(input int unsigned tx_pct,
                                        input int unsigned rx_pct, input int count);
        int target;
        send_idle_pct  = tx_pct;
        recv_stall_pct = rx_pct;
        target = items_sent + count;
        while (items_sent < target) begin
            wait_drain();
            pick_settings();
            play_session($urandom_range(6, 40));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wall_ms        = $urandom;
        send_idle_pct  = 20;
        recv_stall_pct = 69;
        test_idle_controls();
        test_forward_run();
        test_backward_run();
        test_forever_run();
        test_elapsed_ceiling();
        test_output_backpressure();
        test_random_sessions(20, 69, RANDOM_ITEMS);
        test_random_sessions(69, 20, RANDOM_ITEMS);
        test_random_sessions(0, 0, RANDOM_ITEMS);
        wait_drain();
        // Let any stray beat show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d event beats and %0d status beats, %0d of them ending a run,",
                 items_sent, beats_checked, runs_finished);
        $display("over %0d register writes spanning directed, ceiling, hold-off and random runs.",
                 reg_writes);
        if (mismatches == 0 && status_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a timeout several times the slowest good run.
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
